// File: hdl/tsrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrc_pkg: shared types and constants for the texture slot request cache
// Slot phases, cell commands, size class table and sequencer states.
// ----------------------------------------------------------------------------
package tsrc_pkg;

	localparam int CLASS0_SLOTS = 16;
	localparam int CLASS1_SLOTS = 24;
	localparam int CLASS2_SLOTS = 8;
	localparam int CLASS3_SLOTS = 2;
	localparam int TAG_BITS     = 64;
	localparam int NCLASS       = 4;
	localparam int NSLOTS       = CLASS0_SLOTS + CLASS1_SLOTS + CLASS2_SLOTS + CLASS3_SLOTS;
	localparam int SLOT_W       = 6;

	localparam logic [8:0] CLS_W [NCLASS] = '{9'd32, 9'd128, 9'd128, 9'd256};
	localparam logic [8:0] CLS_H [NCLASS] = '{9'd64, 9'd64, 9'd128, 9'd256};
	localparam logic [SLOT_W-1:0] CLS_N [NCLASS] = '{
		SLOT_W'(CLASS0_SLOTS), SLOT_W'(CLASS1_SLOTS),
		SLOT_W'(CLASS2_SLOTS), SLOT_W'(CLASS3_SLOTS)};
	localparam logic [SLOT_W-1:0] CLS_FIRST [NCLASS] = '{
		SLOT_W'(0), SLOT_W'(CLASS0_SLOTS),
		SLOT_W'(CLASS0_SLOTS + CLASS1_SLOTS),
		SLOT_W'(CLASS0_SLOTS + CLASS1_SLOTS + CLASS2_SLOTS)};

	// operation codes
	localparam logic [2:0] OP_REQUEST  = 3'd0;
	localparam logic [2:0] OP_TICK     = 3'd1;
	localparam logic [2:0] OP_TAKE     = 3'd2;
	localparam logic [2:0] OP_COMPLETE = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	// fetch status codes
	localparam logic [1:0] FS_OK      = 2'd0;
	localparam logic [1:0] FS_MISSING = 2'd1;

	// register indexes
	localparam logic REG_RUNNING = 1'b0;
	localparam logic REG_KEEP    = 1'b1;

	typedef enum logic [2:0] {
		PH_FREE, PH_WANTED, PH_RUNNING, PH_READY, PH_NONE
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE, CMD_CLAIM, CMD_TOUCH, CMD_RUN, CMD_FINISH, CMD_CLEAR
	} cmd_kind_t;

	typedef enum logic [2:0] {
		S_IDLE, S_REQ_SCAN, S_REQ_FIN, S_TAKE_SCAN, S_TAKE_FIN
	} seq_state_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [TAG_BITS-1:0]   tag;
		logic [11:0]           want_w;
		logic [11:0]           want_h;
		logic [1:0]            status;
		logic [8:0]            got_w;
		logic [8:0]            got_h;
		logic [31:0]           frame;
		logic [31:0]           order;
	} cell_cmd_t;

	typedef struct packed {
		phase_t                phase;
		logic [TAG_BITS-1:0]   tag;
		logic [11:0]           want_w;
		logic [11:0]           want_h;
		logic [8:0]            got_w;
		logic [8:0]            got_h;
		logic [31:0]           asked;
		logic [31:0]           order;
	} cell_view_t;

	typedef struct packed {
		logic        ready_res;
		logic        waiting;
		logic        dispatched;
		logic [5:0]  slot;
		logic [63:0] tag_out;
		logic [11:0] width;
		logic [11:0] height;
		logic [8:0]  tex_w;
		logic [8:0]  tex_h;
	} result_t;

	function automatic logic [1:0] slot_class(input logic [SLOT_W-1:0] idx);
		logic [1:0] c;
		c = 2'd0;
		for (int k = 1; k < NCLASS; k++)
			if (idx >= CLS_FIRST[k]) c = 2'(k);
		return c;
	endfunction

endpackage

// File: hdl/texture_slot_request_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_slot_request_cache: slot table for size-classed texture requests
// A row of slot cells plus a sequencer that scans them one slot per cycle.
// ----------------------------------------------------------------------------
//
// channel  | signals                                        | handshake
// ---------+------------------------------------------------+--------------------
// command  | operation id_tag req_w req_h slot_index status | start & !busy
//          | fetched_w fetched_h                            |
// result   | ready_res waiting dispatched slot tag_out      | done, one cycle
//          | width height tex_w tex_h                       |
// config   | cfg_index cfg_data                             | cfg_we
//
// Tick, complete, clear and unused codes, and a request with a zero tag or
// no fitting class, finish without a scan: done follows the accepting edge
// and busy stays low. Other requests scan the slots of their size class,
// a take scans all fifty slots. The scan port of the cell row sets the pace.
// Reset leaves every slot free, frame count one, order count zero.
// The receiver cannot stall: done is high for one cycle, and each result stays on the ports until the next is loaded.
//
module texture_slot_request_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [63:0] id_tag,
	input  logic [11:0] req_w,
	input  logic [11:0] req_h,
	input  logic [5:0]  slot_index,
	input  logic [1:0]  status,
	input  logic [8:0]  fetched_w,
	input  logic [8:0]  fetched_h,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic        ready_res,
	output logic        waiting,
	output logic        dispatched,
	output logic [5:0]  slot,
	output logic [63:0] tag_out,
	output logic [11:0] width,
	output logic [11:0] height,
	output logic [8:0]  tex_w,
	output logic [8:0]  tex_h
);

	localparam int SW = tsrc_pkg::SLOT_W;
	localparam int TB = tsrc_pkg::TAG_BITS;
	localparam logic [0:0] REG_RUNNING_IDX = tsrc_pkg::REG_RUNNING;

	// configuration
	logic       running_q;
	logic [7:0] keep_q;

	// sequencer state
	tsrc_pkg::seq_state_t state_q, state_d;
	logic [31:0]  frame_q, order_q;
	logic [SW-1:0] idx_q, end_q;
	logic [1:0]   cls_q;
	logic [TB-1:0] tag_q;
	logic [11:0]  w_q, h_q;

	// request scan results
	logic          match_q, free_q, best_q;
	logic [SW-1:0] match_idx_q, free_idx_q, best_idx_q;
	tsrc_pkg::phase_t match_ph_q;
	logic [8:0]    match_gw_q, match_gh_q;
	logic [31:0]   best_asked_q;

	// take scan results
	logic          tb_q;
	logic [SW-1:0] tb_idx_q;
	logic [31:0]   tb_order_q;
	logic [TB-1:0] tb_tag_q;
	logic [11:0]   tb_w_q, tb_h_q;

	// cell row
	tsrc_pkg::cell_cmd_t  cmd;
	logic [SW-1:0]        cmd_idx;
	logic                 cmd_all;
	tsrc_pkg::cell_view_t views [tsrc_pkg::NSLOTS];
	tsrc_pkg::cell_view_t cur;

	for (genvar i = 0; i < tsrc_pkg::NSLOTS; i++) begin : g_cell
		tsrc_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.sel   (cmd_all || cmd_idx == SW'(i)),
			.cmd   (cmd),
			.view  (views[i])
		);
	end

	assign cur = views[idx_q];

	// size class pick for an incoming request: first class that fits
	logic       fit;
	logic [1:0] fit_cls;
	always_comb begin
		fit = 1'b0;
		fit_cls = 2'd0;
		for (int c = tsrc_pkg::NCLASS - 1; c >= 0; c--)
			if (req_w <= 12'(tsrc_pkg::CLS_W[c]) && req_h <= 12'(tsrc_pkg::CLS_H[c])) begin
				fit = 1'b1;
				fit_cls = 2'(c);
			end
	end

	// per-slot flags of the slot under the scan
	logic [31:0] age;
	logic        hit, claimable, live;
	assign age = frame_q - cur.asked;
	assign hit = cur.phase != tsrc_pkg::PH_FREE && cur.want_w == w_q &&
		cur.want_h == h_q && cur.tag == tag_q;
	assign claimable = cur.phase != tsrc_pkg::PH_FREE && cur.phase != tsrc_pkg::PH_RUNNING &&
		age >= {24'd0, keep_q};
	assign live = cur.phase == tsrc_pkg::PH_WANTED && age <= {24'd0, keep_q};

	// next state, cell command and result word
	logic              accept, res_load, claim_go, scan_last;
	tsrc_pkg::result_t res_d, res_q;
	logic [SW-1:0]     claim_idx;

	assign accept    = start && !busy;
	assign scan_last = idx_q == end_q;
	assign claim_go  = !match_q && running_q && (free_q || best_q);
	assign claim_idx = free_q ? free_idx_q : best_idx_q;

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		res_d    = '0;
		cmd      = '0;
		cmd.kind = tsrc_pkg::CMD_NONE;
		cmd.tag    = tag_q;
		cmd.want_w = w_q;
		cmd.want_h = h_q;
		cmd.frame  = frame_q;
		cmd.order  = order_q + 32'd1;
		cmd_idx  = '0;
		cmd_all  = 1'b0;
		unique case (state_q)
			tsrc_pkg::S_IDLE: begin
				if (accept) begin
					unique case (operation)
						tsrc_pkg::OP_REQUEST: begin
							if (id_tag[TB-1:0] != '0 && fit) state_d = tsrc_pkg::S_REQ_SCAN;
							else res_load = 1'b1;
						end
						tsrc_pkg::OP_TAKE: state_d = tsrc_pkg::S_TAKE_SCAN;
						tsrc_pkg::OP_COMPLETE: begin
							res_load = 1'b1;
							if (slot_index < SW'(tsrc_pkg::NSLOTS)) begin
								cmd.kind   = tsrc_pkg::CMD_FINISH;
								cmd.status = status;
								cmd.got_w  = fetched_w;
								cmd.got_h  = fetched_h;
								cmd_idx    = slot_index;
							end
						end
						tsrc_pkg::OP_CLEAR: begin
							res_load = 1'b1;
							cmd.kind = tsrc_pkg::CMD_CLEAR;
						end
						default: res_load = 1'b1;  // tick and unused codes
					endcase
				end
			end
			tsrc_pkg::S_REQ_SCAN: begin
				if (scan_last) state_d = tsrc_pkg::S_REQ_FIN;
			end
			tsrc_pkg::S_REQ_FIN: begin
				state_d  = tsrc_pkg::S_IDLE;
				res_load = 1'b1;
				if (match_q) begin
					cmd.kind = tsrc_pkg::CMD_TOUCH;
					cmd_idx  = match_idx_q;
					res_d.slot = match_idx_q;
					if (match_ph_q == tsrc_pkg::PH_READY) begin
						res_d.ready_res = 1'b1;
						res_d.width  = 12'(match_gw_q);
						res_d.height = 12'(match_gh_q);
						res_d.tex_w  = tsrc_pkg::CLS_W[cls_q];
						res_d.tex_h  = tsrc_pkg::CLS_H[cls_q];
					end else begin
						res_d.waiting = match_ph_q != tsrc_pkg::PH_NONE;
					end
				end else if (claim_go) begin
					cmd.kind = tsrc_pkg::CMD_CLAIM;
					cmd_idx  = claim_idx;
					res_d.slot    = claim_idx;
					res_d.waiting = 1'b1;
				end else begin
					res_d.waiting = running_q;
				end
			end
			tsrc_pkg::S_TAKE_SCAN: begin
				if (scan_last) state_d = tsrc_pkg::S_TAKE_FIN;
			end
			tsrc_pkg::S_TAKE_FIN: begin
				state_d  = tsrc_pkg::S_IDLE;
				res_load = 1'b1;
				if (tb_q) begin
					cmd.kind = tsrc_pkg::CMD_RUN;
					cmd_idx  = tb_idx_q;
					res_d.dispatched = 1'b1;
					res_d.slot    = tb_idx_q;
					res_d.tag_out = 64'(tb_tag_q);
					res_d.width   = tb_w_q;
					res_d.height  = tb_h_q;
					res_d.tex_w   = tsrc_pkg::CLS_W[tsrc_pkg::slot_class(tb_idx_q)];
					res_d.tex_h   = tsrc_pkg::CLS_H[tsrc_pkg::slot_class(tb_idx_q)];
				end
			end
			default: state_d = tsrc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b1;
			keep_q    <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RUNNING_IDX: running_q <= cfg_data[0];
				default:         keep_q    <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsrc_pkg::S_IDLE;
			frame_q <= 32'd1;
			order_q <= 32'd0;
			done    <= 1'b0;
			idx_q   <= '0;
			end_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			best_q  <= 1'b0;
			tb_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= res_load;
			if (accept && operation == tsrc_pkg::OP_TICK) frame_q <= frame_q + 32'd1;
			if (state_q == tsrc_pkg::S_REQ_FIN && claim_go) order_q <= order_q + 32'd1;

			if (state_q == tsrc_pkg::S_IDLE && state_d == tsrc_pkg::S_REQ_SCAN) begin
				idx_q   <= tsrc_pkg::CLS_FIRST[fit_cls];
				end_q   <= tsrc_pkg::CLS_FIRST[fit_cls] + tsrc_pkg::CLS_N[fit_cls] - SW'(1);
				match_q <= 1'b0;
				free_q  <= 1'b0;
				best_q  <= 1'b0;
			end else if (state_q == tsrc_pkg::S_IDLE && state_d == tsrc_pkg::S_TAKE_SCAN) begin
				idx_q <= '0;
				end_q <= SW'(tsrc_pkg::NSLOTS - 1);
				tb_q  <= 1'b0;
			end else if (state_q == tsrc_pkg::S_REQ_SCAN) begin
				idx_q <= idx_q + SW'(1);
				if (!match_q && hit) match_q <= 1'b1;
				if (!free_q && cur.phase == tsrc_pkg::PH_FREE) free_q <= 1'b1;
				if (claimable && (!best_q || cur.asked < best_asked_q)) best_q <= 1'b1;
			end else if (state_q == tsrc_pkg::S_TAKE_SCAN) begin
				idx_q <= idx_q + SW'(1);
				if (live && (!tb_q || cur.order > tb_order_q)) tb_q <= 1'b1;
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (state_q == tsrc_pkg::S_IDLE && accept) begin
			tag_q <= id_tag[TB-1:0];
			w_q   <= req_w;
			h_q   <= req_h;
			cls_q <= fit_cls;
		end
		if (state_q == tsrc_pkg::S_REQ_SCAN) begin
			if (!match_q && hit) begin
				match_idx_q <= idx_q;
				match_ph_q  <= cur.phase;
				match_gw_q  <= cur.got_w;
				match_gh_q  <= cur.got_h;
			end
			if (!free_q && cur.phase == tsrc_pkg::PH_FREE) free_idx_q <= idx_q;
			if (claimable && (!best_q || cur.asked < best_asked_q)) begin
				best_idx_q   <= idx_q;
				best_asked_q <= cur.asked;
			end
		end
		if (state_q == tsrc_pkg::S_TAKE_SCAN && live && (!tb_q || cur.order > tb_order_q)) begin
			tb_idx_q   <= idx_q;
			tb_order_q <= cur.order;
			tb_tag_q   <= cur.tag;
			tb_w_q     <= cur.want_w;
			tb_h_q     <= cur.want_h;
		end
		if (res_load) res_q <= res_d;
	end

	assign busy       = state_q != tsrc_pkg::S_IDLE;
	assign ready_res  = res_q.ready_res;
	assign waiting    = res_q.waiting;
	assign dispatched = res_q.dispatched;
	assign slot       = res_q.slot;
	assign tag_out    = res_q.tag_out;
	assign width      = res_q.width;
	assign height     = res_q.height;
	assign tex_w      = res_q.tex_w;
	assign tex_h      = res_q.tex_h;

endmodule

// File: hdl/tsrc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrc_cell: one texture slot
// Holds the phase, tag, sizes and stamps of a slot; applies broadcast commands.
// ----------------------------------------------------------------------------
module tsrc_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sel,
	input  tsrc_pkg::cell_cmd_t  cmd,
	output tsrc_pkg::cell_view_t view
);

	tsrc_pkg::phase_t                    phase_q;
	logic [tsrc_pkg::TAG_BITS-1:0]       tag_q;
	logic [11:0]                         want_w_q, want_h_q;
	logic [8:0]                          got_w_q, got_h_q;
	logic [31:0]                         asked_q, order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsrc_pkg::PH_FREE;
		end else begin
			case (cmd.kind)
				tsrc_pkg::CMD_CLAIM: begin
					if (sel) phase_q <= tsrc_pkg::PH_WANTED;
				end
				tsrc_pkg::CMD_RUN: begin
					if (sel) phase_q <= tsrc_pkg::PH_RUNNING;
				end
				tsrc_pkg::CMD_FINISH: begin
					if (sel && phase_q == tsrc_pkg::PH_RUNNING) begin
						if (cmd.status == tsrc_pkg::FS_OK && cmd.got_w != 9'd0)
							phase_q <= tsrc_pkg::PH_READY;
						else if (cmd.status == tsrc_pkg::FS_MISSING)
							phase_q <= tsrc_pkg::PH_NONE;
						else
							phase_q <= tsrc_pkg::PH_FREE;
					end
				end
				tsrc_pkg::CMD_CLEAR: begin
					if (phase_q != tsrc_pkg::PH_RUNNING) phase_q <= tsrc_pkg::PH_FREE;
				end
				default: ;
			endcase
		end
	end

	// payload, no reset needed: only read once the slot has been claimed
	always_ff @(posedge clk) begin
		if (sel) begin
			case (cmd.kind)
				tsrc_pkg::CMD_CLAIM: begin
					tag_q    <= cmd.tag;
					want_w_q <= cmd.want_w;
					want_h_q <= cmd.want_h;
					got_w_q  <= 9'd0;
					got_h_q  <= 9'd0;
					order_q  <= cmd.order;
					asked_q  <= cmd.frame;
				end
				tsrc_pkg::CMD_TOUCH: begin
					asked_q <= cmd.frame;
				end
				tsrc_pkg::CMD_FINISH: begin
					if (phase_q == tsrc_pkg::PH_RUNNING) begin
						got_w_q <= cmd.got_w;
						got_h_q <= cmd.got_h;
					end
				end
				default: ;
			endcase
		end
	end

	assign view = '{phase: phase_q, tag: tag_q, want_w: want_w_q, want_h: want_h_q,
		got_w: got_w_q, got_h: got_h_q, asked: asked_q, order: order_q};

endmodule
